// ----- hw/rtl/nbrtbl_pkg.sv -----
// nbrtbl_pkg: types, constants and codes shared by the neighbor table modules
// no dependencies
package nbrtbl_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_W = 4;

  localparam logic [15:0] GAP_UNITY = 16'h0100;
  localparam logic [8:0] WEIGHT_RESET = 9'h040;
  localparam logic [8:0] WEIGHT_MAX = 9'h100;

  // outcome codes
  localparam logic [1:0] OUT_UPDATED = 2'd0;
  localparam logic [1:0] OUT_ADDED = 2'd1;
  localparam logic [1:0] OUT_DROPPED = 2'd2;

  typedef struct packed {
    logic [15:0] sender_address;
    logic [7:0] sequence_number;
    logic [15:0] signal_strength;
    logic [15:0] link_quality;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [SLOT_W-1:0] slot;
    logic [15:0] average_gap;
  } out_beat_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [15:0] address;
    logic [7:0] prev_seq;
    logic [15:0] average_gap;
    logic [15:0] strength;
    logic [15:0] quality;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic re;
    logic [IDX_W-1:0] raddr;
    logic we;
    logic [IDX_W-1:0] waddr;
    entry_t wdata;
  } ram_req_t;

  typedef struct packed {
    logic load;
    logic [7:0] gap;
    logic [15:0] avg_old;
  } ewma_req_t;

  typedef struct packed {
    logic load;
    out_beat_t data;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CALC,
    ST_WRITE
  } state_t;

endpackage

// ----- hw/rtl/nbrtbl_ram.sv -----
// nbrtbl_ram: generic single write port, single read port synchronous memory
// read data registered; no dependencies
module nbrtbl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/nbrtbl_ewma.sv -----
// nbrtbl_ewma: moving average of the sequence gap, 8.8 fixed point
// products registered, sum and saturation after; depends on nbrtbl_pkg
module nbrtbl_ewma
  import nbrtbl_pkg::*;
(
  input  logic      clk,
  input  ewma_req_t req,
  input  logic [8:0] alpha,
  output logic [15:0] avg_new
);

  logic [15:0] prod_new_r;
  logic [16:0] prod_old_r;
  logic [16:0] prod_new_nxt;
  logic [24:0] prod_old_full;
  logic [8:0] beta;
  logic [17:0] sum;

  always_comb begin
    beta = WEIGHT_MAX - alpha;
    // gap*alpha stays below 65281 since alpha is at most 256
    prod_new_nxt = 17'(req.gap) * 17'(alpha);
    prod_old_full = 25'(req.avg_old) * 25'(beta);
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod_new_r <= prod_new_nxt[15:0];
      prod_old_r <= prod_old_full[24:8];
    end
  end

  always_comb begin
    sum = 18'(prod_new_r) + 18'(prod_old_r);
    avg_new = (sum > 18'h0ffff) ? 16'hffff : sum[15:0];
  end

endmodule

// ----- hw/rtl/nbrtbl_ctrl.sv -----
// nbrtbl_ctrl: sequencer that searches the table one entry a cycle, then updates,
// adds or drops the entry; depends on nbrtbl_pkg, drives nbrtbl_ram and nbrtbl_ewma
module nbrtbl_ctrl
  import nbrtbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  in_beat_t    in_data,
  output logic        in_stall,
  output ram_req_t    ram_req,
  input  entry_t      ram_rdata,
  output ewma_req_t   ewma_req,
  input  logic [15:0] avg_new,
  input  logic        out_busy,
  output result_t     res
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  in_beat_t beat_r, beat_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [7:0] last_r, last_nxt;
  logic [15:0] avg_old_r, avg_old_nxt;
  logic is_new_r, is_new_nxt;
  logic drop_r, drop_nxt;

  logic accept;
  logic issue;
  logic match;
  logic miss;
  logic full;

  assign accept = in_valid && (state_r == ST_IDLE);
  assign issue = (iss_r < fill_r);
  assign match = cmp_vld_r && (ram_rdata.address == beat_r.sender_address);
  assign miss = !issue && !match;
  assign full = (fill_r == CNT_W'(TABLE_ENTRIES));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (match || miss) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);

    ram_req.re = (state_r == ST_SEARCH) && issue;
    ram_req.raddr = iss_r[IDX_W-1:0];
    ram_req.we = (state_r == ST_WRITE) && !out_busy && !drop_r;
    ram_req.waddr = slot_r;
    ram_req.wdata.address = beat_r.sender_address;
    ram_req.wdata.prev_seq = beat_r.sequence_number;
    ram_req.wdata.average_gap = avg_new;
    ram_req.wdata.strength = beat_r.signal_strength;
    ram_req.wdata.quality = beat_r.link_quality;

    ewma_req.load = (state_r == ST_CALC);
    ewma_req.gap = beat_r.sequence_number - last_r;
    ewma_req.avg_old = avg_old_r;

    res.load = (state_r == ST_WRITE) && !out_busy;
    if (drop_r) begin
      res.data.outcome = OUT_DROPPED;
      res.data.slot = '0;
      res.data.average_gap = '0;
    end else begin
      res.data.outcome = is_new_r ? OUT_ADDED : OUT_UPDATED;
      res.data.slot = SLOT_W'(slot_r);
      res.data.average_gap = avg_new;
    end
  end

  // datapath
  always_comb begin
    fill_nxt = fill_r;
    iss_nxt = iss_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    beat_nxt = beat_r;
    slot_nxt = slot_r;
    last_nxt = last_r;
    avg_old_nxt = avg_old_r;
    is_new_nxt = is_new_r;
    drop_nxt = drop_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          beat_nxt = in_data;
          iss_nxt = '0;
          cmp_vld_nxt = 1'b0;
        end
      end
      ST_SEARCH: begin
        iss_nxt = issue ? iss_r + 1'b1 : iss_r;
        cmp_vld_nxt = issue;
        cmp_idx_nxt = iss_r[IDX_W-1:0];
        if (match) begin
          slot_nxt = cmp_idx_r;
          last_nxt = ram_rdata.prev_seq;
          avg_old_nxt = ram_rdata.average_gap;
          is_new_nxt = 1'b0;
          drop_nxt = 1'b0;
        end else if (miss) begin
          // fill level is the lowest free slot: entries are never removed
          slot_nxt = fill_r[IDX_W-1:0];
          last_nxt = beat_r.sequence_number - 8'd1;
          avg_old_nxt = GAP_UNITY;
          is_new_nxt = 1'b1;
          drop_nxt = full;
        end
      end
      ST_CALC: begin
      end
      ST_WRITE: begin
        if (!out_busy && is_new_r && !drop_r) fill_nxt = fill_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r <= iss_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    beat_r <= beat_nxt;
    slot_r <= slot_nxt;
    last_r <= last_nxt;
    avg_old_r <= avg_old_nxt;
    is_new_r <= is_new_nxt;
    drop_r <= drop_nxt;
  end

endmodule

// ----- hw/rtl/neighbor_table_seqno_gap_ewma_top.sv -----
// a beat runs through the search, calc and write states; a hit ends the search at
// its slot, a miss after every filled entry; write waits while the output is stalled
// and the input stays stalled until the state is back to idle; the search scans one
// table entry per cycle through the one table read port
// reset: synchronous rst_n clears the fill count (empty table), the weight to 64 and
// the handshake state; the table memory itself is not cleared
module neighbor_table_seqno_gap_ewma_top
  import nbrtbl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_beat_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output out_beat_t out_data,
  input  logic      out_stall,
  input  logic      cfg_we,
  input  logic [8:0] cfg_wdata
);

  logic [8:0] weight_r;
  logic [8:0] alpha;
  logic out_valid_r, out_valid_nxt;
  out_beat_t out_data_r;
  logic out_busy;

  ram_req_t ram_req;
  entry_t ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  ewma_req_t ewma_req;
  logic [15:0] avg_new;
  result_t res;

  // weights above unity act as unity
  assign alpha = (weight_r > WEIGHT_MAX) ? WEIGHT_MAX : weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_we) begin
      weight_r <= cfg_wdata;
    end
  end

  nbrtbl_ram #(
    .DEPTH(TABLE_ENTRIES),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .re   (ram_req.re),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  nbrtbl_ewma u_ewma (
    .clk    (clk),
    .req    (ewma_req),
    .alpha  (alpha),
    .avg_new(avg_new)
  );

  nbrtbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .ram_req  (ram_req),
    .ram_rdata(ram_rdata),
    .ewma_req (ewma_req),
    .avg_new  (avg_new),
    .out_busy (out_busy),
    .res      (res)
  );

  // output register parts the result side from the search
  assign out_busy = out_valid_r && out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled output beat");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res.load && (res.data.outcome == OUT_DROPPED) |->
      (res.data.slot == '0) && (res.data.average_gap == '0))
    else $error("dropped beat carries nonzero slot or average");

  a_load_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> in_stall)
    else $error("result produced with no beat in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while a beat is being worked on");
`endif

endmodule
